FILE: rtl/core/pcd_pkg.sv
// Package for the Pearson correlation distance block.
// Holds payload structs, state/command enums and fixed widths.
// No dependencies.
`default_nettype none
package pcd_pkg;

  localparam int DATA_W = 16;
  localparam int DIST_W = 18;
  localparam int CNT_W  = 17;
  localparam int SUM_W  = 32;
  localparam int SQ_W   = 48;
  localparam int LIMB_W = 32;
  localparam int ACC_W  = 192;

  localparam logic [3:0]  MAC_LAST = 4'd8;
  localparam logic [17:0] TWO_Q16  = 18'd131072;
  localparam logic [18:0] M_BASE   = 19'd131073;

  typedef struct packed {
    logic [DATA_W-1:0] abundance_a;
    logic [DATA_W-1:0] abundance_b;
    logic              last_bin;
  } pcd_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              degenerate;
  } pcd_out_t;

  typedef enum logic [3:0] {
    OP_SFS_N, OP_SF_SF, OP_SSS_N, OP_SB_SB, OP_SCP_N, OP_SF_SB,
    OP_SXX_SYY, OP_C_C, OP_M_M, OP_V_MSQ
  } pcd_op_t;

  typedef enum logic [2:0] {
    ST_NONE, ST_SXX, ST_SYY, ST_C, ST_V, ST_L, ST_MSQ
  } pcd_store_t;

  typedef enum logic [3:0] {
    S_ACCUM, S_SXX_A, S_SXX_B, S_SYY_A, S_SYY_B, S_C_A, S_C_B, S_CHECK,
    S_V, S_L, S_SEARCH, S_MSQ, S_RMUL, S_CMP, S_DONE
  } pcd_state_t;

  typedef struct packed {
    logic       accum;
    logic       clear_sums;
    logic       mac_go;
    pcd_op_t    op;
    logic       acc_clear;
    logic       acc_sub;
    pcd_store_t store;
    logic       prep;
    logic       search_upd;
    logic       use_cmp;
    logic       load_out;
  } pcd_cmd_t;

  typedef struct packed {
    logic mac_done;
    logic degen;
    logic search_done;
    logic quick_valid;
  } pcd_status_t;

endpackage
`default_nettype wire

FILE: rtl/core/pearson_correlation_distance_top.sv
// Pearson correlation distance, top level.
// Depends on pcd_pkg, pcd_ctrl, pcd_dp.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_data): one bin pair per transaction,
//    last_bin marks the final pair of a vector. While accumulating, one
//    transaction is taken every cycle.
//  - Output channel (out_valid/out_ready/out_data): one transaction per
//    vector, distance = 1 - r in Q2.16 (0..2.0), degenerate when a
//    variance is zero (distance then 0).
//  - After the last pair the block stops taking input and finishes: six
//    passes of a shared 32x32 multiply-accumulate form the centered sums,
//    two more form Sxx*Syy and C*C, then a bisection of up to 18 steps on
//    the rounded distance runs, each step decided either by sign alone or
//    by two more MAC passes and a compare. The degenerate case skips the
//    Sxx*Syy and C*C passes and the bisection.
//  - The result sits in an output register; the next vector's pairs are
//    accepted while it waits. A stalled receiver only blocks the block once
//    the following result is ready.
//  - rst (synchronous, active high) clears the sums and drops out_valid.
`default_nettype none
module pearson_correlation_distance_top #(
  parameter int MAX_BINS       = 65536,
  parameter int ABUNDANCE_BITS = 16
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  pcd_pkg::pcd_in_t  in_data,
  output logic              out_valid,
  input  wire               out_ready,
  output pcd_pkg::pcd_out_t out_data
);
  import pcd_pkg::*;

  pcd_cmd_t    cmd;
  pcd_status_t status;

  // control: handshake, sequencing of finish steps
  pcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_data.last_bin),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: sums, MAC unit, bisection and result register
  pcd_dp #(
    .MAX_BINS       (MAX_BINS),
    .ABUNDANCE_BITS (ABUNDANCE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

FILE: rtl/core/pcd_ctrl.sv
// Controller FSM: sequences accumulation, the MAC passes and the search.
// Depends on pcd_pkg.
`default_nettype none
module pcd_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  wire                 in_last,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  input  pcd_pkg::pcd_status_t status,
  output pcd_pkg::pcd_cmd_t    cmd
);
  import pcd_pkg::*;

  pcd_state_t state, state_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACCUM;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_ACCUM: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accum = 1'b1;
          if (in_last) state_next = S_SXX_A;
        end
      end
      S_SXX_A: begin
        cmd.mac_go = 1'b1; cmd.op = OP_SFS_N; cmd.acc_clear = 1'b1;
        if (status.mac_done) state_next = S_SXX_B;
      end
      S_SXX_B: begin
        cmd.mac_go = 1'b1; cmd.op = OP_SF_SF; cmd.acc_sub = 1'b1;
        if (status.mac_done) begin
          cmd.store  = ST_SXX;
          state_next = S_SYY_A;
        end
      end
      S_SYY_A: begin
        cmd.mac_go = 1'b1; cmd.op = OP_SSS_N; cmd.acc_clear = 1'b1;
        if (status.mac_done) state_next = S_SYY_B;
      end
      S_SYY_B: begin
        cmd.mac_go = 1'b1; cmd.op = OP_SB_SB; cmd.acc_sub = 1'b1;
        if (status.mac_done) begin
          cmd.store  = ST_SYY;
          state_next = S_C_A;
        end
      end
      S_C_A: begin
        cmd.mac_go = 1'b1; cmd.op = OP_SCP_N; cmd.acc_clear = 1'b1;
        if (status.mac_done) state_next = S_C_B;
      end
      S_C_B: begin
        cmd.mac_go = 1'b1; cmd.op = OP_SF_SB; cmd.acc_sub = 1'b1;
        if (status.mac_done) begin
          cmd.store  = ST_C;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.prep   = 1'b1;
        state_next = status.degen ? S_DONE : S_V;
      end
      S_V: begin
        cmd.mac_go = 1'b1; cmd.op = OP_SXX_SYY; cmd.acc_clear = 1'b1;
        if (status.mac_done) begin
          cmd.store  = ST_V;
          state_next = S_L;
        end
      end
      S_L: begin
        cmd.mac_go = 1'b1; cmd.op = OP_C_C; cmd.acc_clear = 1'b1;
        if (status.mac_done) begin
          cmd.store  = ST_L;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (status.search_done) begin
          state_next = S_DONE;
        end else if (status.quick_valid) begin
          cmd.search_upd = 1'b1;
        end else begin
          state_next = S_MSQ;
        end
      end
      S_MSQ: begin
        cmd.mac_go = 1'b1; cmd.op = OP_M_M; cmd.acc_clear = 1'b1;
        if (status.mac_done) begin
          cmd.store  = ST_MSQ;
          state_next = S_RMUL;
        end
      end
      S_RMUL: begin
        cmd.mac_go = 1'b1; cmd.op = OP_V_MSQ; cmd.acc_clear = 1'b1;
        if (status.mac_done) state_next = S_CMP;
      end
      S_CMP: begin
        cmd.search_upd = 1'b1;
        cmd.use_cmp    = 1'b1;
        state_next     = S_SEARCH;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          cmd.clear_sums = 1'b1;
          state_next     = S_ACCUM;
        end
      end
      default: state_next = S_ACCUM;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

endmodule
`default_nettype wire

FILE: rtl/core/pcd_dp.sv
// Datapath: running sums, shared 32x32 multiply-accumulate, search registers.
// Depends on pcd_pkg.
`default_nettype none
module pcd_dp #(
  parameter int MAX_BINS       = 65536,
  parameter int ABUNDANCE_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  pcd_pkg::pcd_in_t     in_data,
  input  pcd_pkg::pcd_cmd_t    cmd,
  output pcd_pkg::pcd_status_t status,
  output pcd_pkg::pcd_out_t    out_data
);
  import pcd_pkg::*;

  localparam logic [DATA_W-1:0] AMASK   = DATA_W'((32'd1 << ABUNDANCE_BITS) - 32'd1);
  localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_BINS);

  logic [SUM_W-1:0] sf, sb;
  logic [SQ_W-1:0]  sfs, sss, scp;
  logic [CNT_W-1:0] cnt;
  logic [DATA_W-1:0] a_m, b_m;
  logic [2*DATA_W-1:0] aa, bb, ab;

  assign a_m = in_data.abundance_a & AMASK;
  assign b_m = in_data.abundance_b & AMASK;
  assign aa  = a_m * a_m;
  assign bb  = b_m * b_m;
  assign ab  = a_m * b_m;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_sums) begin
      sf <= '0; sb <= '0; sfs <= '0; sss <= '0; scp <= '0; cnt <= '0;
    end else if (cmd.accum && (cnt < MAX_CNT)) begin
      sf  <= sf + SUM_W'(a_m);
      sb  <= sb + SUM_W'(b_m);
      sfs <= sfs + SQ_W'(aa);
      sss <= sss + SQ_W'(bb);
      scp <= scp + SQ_W'(ab);
      cnt <= cnt + 1'b1;
    end
  end

  // finish registers
  logic [63:0]  sxx, syy, cmag, msq;
  logic [64:0]  c_raw;
  logic [127:0] v, l;
  logic         cneg, czero;
  logic [17:0]  lo, hi, mid, mabs;
  logic [18:0]  m;

  // multiply-accumulate: 4 x 2 limbs, one partial product per step
  logic [3:0]        step;
  logic [127:0]      opx;
  logic [63:0]       opy;
  logic [LIMB_W-1:0] xl, yl;
  logic [63:0]       pp;
  logic [2:0]        pp_sh;
  logic [ACC_W-1:0]  acc, addend, acc_final;

  always_comb begin
    case (cmd.op)
      OP_SFS_N:   begin opx = 128'(sfs);  opy = 64'(cnt);  end
      OP_SF_SF:   begin opx = 128'(sf);   opy = 64'(sf);   end
      OP_SSS_N:   begin opx = 128'(sss);  opy = 64'(cnt);  end
      OP_SB_SB:   begin opx = 128'(sb);   opy = 64'(sb);   end
      OP_SCP_N:   begin opx = 128'(scp);  opy = 64'(cnt);  end
      OP_SF_SB:   begin opx = 128'(sf);   opy = 64'(sb);   end
      OP_SXX_SYY: begin opx = 128'(sxx);  opy = syy;       end
      OP_C_C:     begin opx = 128'(cmag); opy = cmag;      end
      OP_M_M:     begin opx = 128'(mabs); opy = 64'(mabs); end
      OP_V_MSQ:   begin opx = v;          opy = msq;       end
      default:    begin opx = '0;         opy = '0;        end
    endcase
  end

  assign xl        = opx[32*step[1:0] +: LIMB_W];
  assign yl        = step[2] ? opy[63:32] : opy[31:0];
  assign addend    = ACC_W'(pp) << {pp_sh, 5'b0};
  assign acc_final = cmd.acc_sub ? (acc - addend) : (acc + addend);

  always_ff @(posedge clk) begin
    if (rst || !cmd.mac_go) step <= '0;
    else if (step == MAC_LAST) step <= '0;
    else step <= step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_go) begin
      if (step != MAC_LAST) begin
        pp    <= xl * yl;
        pp_sh <= {1'b0, step[1:0]} + {2'b0, step[2]};
      end
      if (step == '0) begin
        if (cmd.acc_clear) acc <= '0;
      end else begin
        acc <= acc_final;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.store)
      ST_SXX:  sxx   <= acc_final[63:0];
      ST_SYY:  syy   <= acc_final[63:0];
      ST_C:    c_raw <= acc_final[64:0];
      ST_V:    v     <= acc_final[127:0];
      ST_L:    l     <= acc_final[127:0];
      ST_MSQ:  msq   <= acc_final[63:0];
      default: ;
    endcase
  end

  // bisection on the rounded distance
  logic c_pos, m_neg, quick_take, cmp_take, take;
  logic [ACC_W-1:0] lhs;

  assign mid        = 18'((19'(lo) + 19'(hi) + 19'd1) >> 1);
  assign m          = M_BASE - {mid, 1'b0};
  assign m_neg      = m[18];
  assign mabs       = m_neg ? 18'(-m) : m[17:0];
  assign c_pos      = !cneg && !czero;
  assign quick_take = !c_pos && !m_neg;
  assign lhs        = {30'b0, l, 34'b0};
  assign cmp_take   = c_pos ? (lhs <= acc) : (lhs >= acc);
  assign take       = cmd.use_cmp ? cmp_take : quick_take;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      cneg  <= c_raw[64];
      czero <= (c_raw == '0);
      cmag  <= c_raw[64] ? (~c_raw[63:0] + 64'd1) : c_raw[63:0];
      lo    <= '0;
      hi    <= TWO_Q16;
    end else if (cmd.search_upd) begin
      if (take) lo <= mid;
      else hi <= mid - 18'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.distance   <= status.degen ? '0 : ((lo > TWO_Q16) ? TWO_Q16 : lo);
      out_data.degenerate <= status.degen;
    end
  end

  assign status.mac_done    = cmd.mac_go && (step == MAC_LAST);
  assign status.degen       = (sxx == '0) || (syy == '0);
  assign status.search_done = (lo >= hi);
  assign status.quick_valid = (!c_pos && !m_neg) || (c_pos && (m_neg || (m == '0)));

endmodule
`default_nettype wire

FILE: rtl/core/pcd_checker.sv
// Port-level checker for the Pearson correlation distance top, with bind.
// Depends on pcd_pkg and pearson_correlation_distance_top.
`default_nettype none
module pcd_checker (
  input wire               clk,
  input wire               rst,
  input wire               in_valid,
  input wire               in_ready,
  input wire               out_valid,
  input wire               out_ready,
  input pcd_pkg::pcd_out_t out_data
);
  import pcd_pkg::*;

  a_rst_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input transaction withdrawn before accept");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.distance <= TWO_Q16)
    else $error("distance above 2.0");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.degenerate |-> out_data.distance == '0)
    else $error("degenerate result with nonzero distance");

endmodule

bind pearson_correlation_distance_top pcd_checker u_pcd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for pearson_correlation_distance_top.
// Depends on pcd_pkg and the block's RTL; predicts each distance with exact wide integers.
`timescale 1ns / 1ps
module tb;
  import pcd_pkg::*;

  localparam int TWO_Q = 131072;
  localparam int CYCLE_LIMIT = 3000000;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  pcd_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  pcd_out_t out_data;

  pearson_correlation_distance_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // bins waiting to be sent, distances waiting to come back
  pcd_in_t  bin_queue[$];
  pcd_out_t distance_queue[$];

  // running sums, wrapped at 64 bits as the arithmetic is defined
  logic [63:0] acc_a, acc_b, acc_aa, acc_bb, acc_ab;
  int unsigned acc_n;
  int errors;
  int cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Is r*131072 <= m, i.e. C*131072 <= m*sqrt(var_prod)?  cross_sq is C^2 * 2^34.
  function automatic bit r_at_most(bit c_neg, bit c_zero, logic [255:0] cross_sq,
                                   logic [255:0] var_prod, longint m);
    logic [255:0] am;
    logic [255:0] rhs;
    bit c_pos;
    c_pos = !c_neg && !c_zero;
    if (!c_pos && m >= 0) return 1;
    if (c_pos && m <= 0) return 0;
    am = (m < 0) ? -m : m;
    rhs = am * am * var_prod;
    return c_pos ? (cross_sq <= rhs) : (cross_sq >= rhs);
  endfunction

  // Distance 1 - r in Q2.16 from the current sums; degenerate on zero variance.
  function automatic pcd_out_t correlation_distance();
    pcd_out_t res;
    logic [63:0] n, sxx, syy, p, q, cmag;
    logic [255:0] var_prod, cross_sq;
    bit c_neg;
    int unsigned lo, hi, mid;
    longint m;
    n = acc_n;
    sxx = n * acc_aa - acc_a * acc_a;
    syy = n * acc_bb - acc_b * acc_b;
    p = n * acc_ab;
    q = acc_a * acc_b;
    res.distance = '0;
    res.degenerate = 1'b1;
    if (sxx == 0 || syy == 0) return res;
    res.degenerate = 1'b0;
    c_neg = p < q;
    cmag = c_neg ? q - p : p - q;
    var_prod = 256'(sxx) * 256'(syy);
    cross_sq = (256'(cmag) * 256'(cmag)) << 34;
    lo = 0;
    hi = TWO_Q;
    // largest d with d <= (1 - r)*65536 + 1/2
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      m = longint'(TWO_Q + 1) - 2 * longint'(mid);
      if (r_at_most(c_neg, cmag == 0, cross_sq, var_prod, m)) lo = mid;
      else hi = mid - 1;
    end
    res.distance = DIST_W'(lo);
    return res;
  endfunction

  task automatic clear_sums();
    acc_a = 0; acc_b = 0; acc_aa = 0; acc_bb = 0; acc_ab = 0; acc_n = 0;
  endtask

  // Fold one accepted bin pair into the sums; a last pair queues a distance.
  task automatic accumulate_bin(pcd_in_t t);
    logic [63:0] a, b;
    a = t.abundance_a;
    b = t.abundance_b;
    if (acc_n < 65536) begin
      acc_a += a; acc_b += b;
      acc_aa += a * a; acc_bb += b * b; acc_ab += a * b;
      acc_n++;
    end
    if (t.last_bin) begin
      distance_queue.push_back(correlation_distance());
      clear_sums();
    end
  endtask

  task automatic add_bin(int a, int b, bit last);
    pcd_in_t t;
    t.abundance_a = a[15:0];
    t.abundance_b = b[15:0];
    t.last_bin = last;
    bin_queue.push_back(t);
  endtask

  // Random vector pair; mode picks how b relates to a.
  task automatic add_vector(int len, int mode);
    int a, b, span, base;
    span = $urandom_range(0, 3) == 0 ? 3 : 65535;
    base = $urandom_range(0, 65535 - span);
    for (int i = 0; i < len; i++) begin
      a = base + $urandom_range(0, span);
      case (mode)
        0: b = $urandom_range(0, 65535);
        1: b = a;
        2: b = 65535 - a;
        3: b = (a / 2 + $urandom_range(0, 2000)) & 16'hffff;
        default: b = $urandom_range(0, 1) ? 0 : 65535;
      endcase
      add_bin(a, b, i == len - 1);
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) accumulate_bin(in_data);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (bin_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= bin_queue.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls on its own pattern and checks each transaction in order.
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 3;
    end else begin
      if (out_valid && out_ready) begin
        if (distance_queue.size() == 0) begin
          $display("%0t: unexpected result, actual dist=%0d degen=%0b", $time,
                   out_data.distance, out_data.degenerate);
          errors++;
        end else begin
          pcd_out_t exp_res;
          exp_res = distance_queue.pop_front();
          if (out_data.distance !== exp_res.distance) begin
            $display("%0t: distance expected %0d actual %0d", $time,
                     exp_res.distance, out_data.distance);
            errors++;
          end
          if (out_data.degenerate !== exp_res.degenerate) begin
            $display("%0t: degenerate expected %0b actual %0b", $time,
                     exp_res.degenerate, out_data.degenerate);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 600);
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("pearson_correlation_distance_top: mismatch");
      $finish;
    end
  end

  initial begin
    int len;
    errors = 0;
    cycles = 0;
    clear_sums();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;

    // directed: single bin, constant and zero vectors, exact +/-1, extremes
    add_bin(65535, 65535, 1);
    add_bin(0, 0, 0); add_bin(0, 0, 1);
    add_bin(7, 1, 0); add_bin(7, 2, 0); add_bin(7, 3, 1);
    add_bin(0, 0, 0); add_bin(65535, 65535, 1);
    add_bin(0, 65535, 0); add_bin(65535, 0, 1);
    add_bin(65535, 0, 0); add_bin(0, 0, 0); add_bin(32768, 65535, 1);
    add_bin(1, 5, 0); add_bin(2, 3, 0); add_bin(3, 9, 0); add_bin(4, 1, 1);
    add_bin(21845, 43690, 0); add_bin(43690, 21845, 0); add_bin(43690, 43690, 1);

    // random vectors: mostly short, a few long
    while (bin_queue.size() < 640) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 10);
      add_vector(len, $urandom_range(0, 4));
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (bin_queue.size() > 0 || in_valid || distance_queue.size() > 0)
      @(posedge clk);
    repeat (500) @(posedge clk);

    if (errors == 0) begin
      $display("pearson_correlation_distance_top: match");
    end else begin
      $display("pearson_correlation_distance_top: mismatch");
    end
    $finish;
  end
endmodule
